// ===== rtl/gds_pkg.sv =====
// gds_pkg: shared types, constants and arithmetic helpers for the 3x downsample block
package gds_pkg;

	localparam int CHAN_W     = 16;
	localparam int DIV_SHIFT  = 4;
	localparam int SUM_W      = CHAN_W + DIV_SHIFT;
	localparam int MAX_OUT_W  = 1024;
	localparam int COL_W      = $clog2(MAX_OUT_W);
	localparam int DIM_W      = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int ROUND_HALF = 1 << (DIV_SHIFT - 1);

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [DIM_W-1:0]  dim_t;
	typedef logic [1:0]        phase_t;

	localparam phase_t PH_FIRST = 2'd0;
	localparam phase_t PH_MID   = 2'd1;
	localparam phase_t PH_LAST  = 2'd2;

	localparam dim_t RST_WIDTH  = 11'd640;
	localparam dim_t RST_HEIGHT = 11'd480;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILTER_ENABLE = 2'd0,
		REG_OUT_WIDTH     = 2'd1,
		REG_OUT_HEIGHT    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		chan_t pixel_r;
		chan_t pixel_g;
		chan_t pixel_b;
	} pix_t;

	typedef struct packed {
		chan_t out_r;
		chan_t out_g;
		chan_t out_b;
		logic  frame_last;
	} res_t;

	typedef struct packed {
		sum_t r;
		sum_t g;
		sum_t b;
	} sum3_t;

	// per-beat control handed from the counters to the datapath
	typedef struct packed {
		logic   bypass;
		phase_t phase_x;
		phase_t phase_y;
		col_t   col;
		logic   emit;
		logic   last;
	} ctl_t;

	// last valid index for a dimension register: zero reads as one, large values saturate
	function automatic col_t dim_last(dim_t v);
		col_t r;
		if (v == '0) begin
			r = '0;
		end else if (v > DIM_W'(MAX_OUT_W)) begin
			r = COL_W'(MAX_OUT_W - 1);
		end else begin
			r = COL_W'(v - 1'b1);
		end
		return r;
	endfunction

	// base plus value, value optionally doubled; wraps at the sum width
	function automatic sum_t acc_add(sum_t base, sum_t val, logic dbl);
		sum_t addend;
		addend = dbl ? {val[SUM_W-2:0], 1'b0} : val;
		return base + addend;
	endfunction

	// divide by 16, round half up
	function automatic chan_t round_sum(sum_t s);
		logic [SUM_W:0] t;
		t = {1'b0, s} + (SUM_W + 1)'(ROUND_HALF);
		return t[DIV_SHIFT +: CHAN_W];
	endfunction

endpackage

// ===== rtl/gds_ifs.sv =====
// gds_ifs: valid/ready stream interfaces for input pixels and result pixels
interface gds_pix_if;
	logic          valid;
	logic          ready;
	gds_pkg::pix_t data;

	modport src (output valid, output data, input ready);
	modport snk (input valid, input data, output ready);
endinterface

interface gds_res_if;
	logic          valid;
	logic          ready;
	gds_pkg::res_t data;

	modport src (output valid, output data, input ready);
	modport snk (input valid, input data, output ready);
endinterface

// ===== rtl/gds_ctrl.sv =====
// gds_ctrl: configuration registers and the raster / block position counters
module gds_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [gds_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [gds_pkg::DIM_W-1:0]           cfg_wdata,
	input  logic                                accept,
	output gds_pkg::ctl_t                       nxt
);

	logic              filt_en_q;
	gds_pkg::dim_t     width_q;
	gds_pkg::dim_t     height_q;
	gds_pkg::col_t     col_q;
	gds_pkg::col_t     row_q;
	gds_pkg::phase_t   phx_q;
	gds_pkg::phase_t   phy_q;

	gds_pkg::col_t     col_d;
	gds_pkg::col_t     row_d;
	gds_pkg::phase_t   phx_d;
	gds_pkg::phase_t   phy_d;
	gds_pkg::col_t     w_last;
	gds_pkg::col_t     h_last;
	logic              col_end;
	logic              row_end;
	logic              cfg_hit;
	logic              blk_done;

	always_comb begin
		w_last   = gds_pkg::dim_last(width_q);
		h_last   = gds_pkg::dim_last(height_q);
		col_end  = col_q >= w_last;
		row_end  = row_q >= h_last;
		blk_done = (phx_q == gds_pkg::PH_LAST) && (phy_q == gds_pkg::PH_LAST);
	end

	always_comb begin
		unique case (gds_pkg::cfg_reg_t'(cfg_idx))
			gds_pkg::REG_FILTER_ENABLE,
			gds_pkg::REG_OUT_WIDTH,
			gds_pkg::REG_OUT_HEIGHT: cfg_hit = cfg_we;
			default:                 cfg_hit = 1'b0;
		endcase
	end

	always_comb begin
		nxt.bypass  = !filt_en_q;
		nxt.phase_x = phx_q;
		nxt.phase_y = phy_q;
		nxt.col     = col_q;
		nxt.emit    = !filt_en_q || blk_done;
		nxt.last    = (!filt_en_q || blk_done) && col_end && row_end;
	end

	always_comb begin
		col_d = col_q;
		row_d = row_q;
		phx_d = phx_q;
		phy_d = phy_q;
		if (!filt_en_q) begin
			phx_d = gds_pkg::PH_FIRST;
			phy_d = gds_pkg::PH_FIRST;
			if (col_end) begin
				col_d = '0;
				row_d = row_end ? '0 : row_q + 1'b1;
			end else begin
				col_d = col_q + 1'b1;
			end
		end else if (phx_q != gds_pkg::PH_LAST) begin
			phx_d = phx_q + 1'b1;
		end else begin
			phx_d = gds_pkg::PH_FIRST;
			if (col_end) begin
				col_d = '0;
				if (phy_q == gds_pkg::PH_LAST) begin
					phy_d = gds_pkg::PH_FIRST;
					row_d = row_end ? '0 : row_q + 1'b1;
				end else begin
					phy_d = phy_q + 1'b1;
				end
			end else begin
				col_d = col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_en_q <= 1'b1;
			width_q   <= gds_pkg::RST_WIDTH;
			height_q  <= gds_pkg::RST_HEIGHT;
		end else if (cfg_we) begin
			unique case (gds_pkg::cfg_reg_t'(cfg_idx))
				gds_pkg::REG_FILTER_ENABLE: filt_en_q <= cfg_wdata[0];
				gds_pkg::REG_OUT_WIDTH:     width_q   <= cfg_wdata;
				gds_pkg::REG_OUT_HEIGHT:    height_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// any register write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			phx_q <= gds_pkg::PH_FIRST;
			phy_q <= gds_pkg::PH_FIRST;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
			phx_q <= gds_pkg::PH_FIRST;
			phy_q <= gds_pkg::PH_FIRST;
		end else if (accept) begin
			col_q <= col_d;
			row_q <= row_d;
			phx_q <= phx_d;
			phy_q <= phy_d;
		end
	end

endmodule

// ===== rtl/gds_line_store.sv =====
// gds_line_store: column partial sums, one entry per output column, registered read
module gds_line_store (
	input  logic                   clk,
	input  logic                   rd_en,
	input  gds_pkg::col_t          rd_addr,
	output gds_pkg::sum3_t         rd_data,
	input  logic                   wr_en,
	input  gds_pkg::col_t          wr_addr,
	input  gds_pkg::sum3_t         wr_data
);

	gds_pkg::sum3_t mem [gds_pkg::MAX_OUT_W];
	gds_pkg::sum3_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== rtl/gds_datapath.sv =====
// gds_datapath: input stage, weighted block accumulation and result register
module gds_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  gds_pkg::pix_t          in_data,
	input  gds_pkg::ctl_t          in_ctl,
	output logic                   in_ready,
	input  gds_pkg::sum3_t         col_rd,
	output logic                   wr_en,
	output gds_pkg::col_t          wr_addr,
	output gds_pkg::sum3_t         wr_data,
	output logic                   res_valid,
	input  logic                   res_ready,
	output gds_pkg::res_t          res_data
);

	logic            vld_s1;
	gds_pkg::pix_t   px_s1;
	gds_pkg::ctl_t   ctl_s1;
	gds_pkg::sum3_t  row_acc_q;
	gds_pkg::res_t   res_q;
	logic            res_valid_q;

	logic            adv;
	gds_pkg::sum3_t  row_base;
	gds_pkg::sum3_t  row_sum;
	gds_pkg::sum3_t  col_base;
	gds_pkg::sum3_t  col_sum;
	gds_pkg::res_t   res_d;
	logic            x_dbl;
	logic            y_dbl;

	// non-emitting beats leave the input stage regardless of the output side
	assign adv      = vld_s1 && (!ctl_s1.emit || !res_valid_q || res_ready);
	assign in_ready = !vld_s1 || adv;

	always_comb begin
		x_dbl    = ctl_s1.phase_x == gds_pkg::PH_MID;
		y_dbl    = ctl_s1.phase_y == gds_pkg::PH_MID;
		row_base = (ctl_s1.phase_x == gds_pkg::PH_FIRST) ? '0 : row_acc_q;
		col_base = (ctl_s1.phase_y == gds_pkg::PH_FIRST) ? '0 : col_rd;

		row_sum.r = gds_pkg::acc_add(row_base.r, gds_pkg::SUM_W'(px_s1.pixel_r), x_dbl);
		row_sum.g = gds_pkg::acc_add(row_base.g, gds_pkg::SUM_W'(px_s1.pixel_g), x_dbl);
		row_sum.b = gds_pkg::acc_add(row_base.b, gds_pkg::SUM_W'(px_s1.pixel_b), x_dbl);

		col_sum.r = gds_pkg::acc_add(col_base.r, row_sum.r, y_dbl);
		col_sum.g = gds_pkg::acc_add(col_base.g, row_sum.g, y_dbl);
		col_sum.b = gds_pkg::acc_add(col_base.b, row_sum.b, y_dbl);

		if (ctl_s1.bypass) begin
			res_d.out_r = px_s1.pixel_r;
			res_d.out_g = px_s1.pixel_g;
			res_d.out_b = px_s1.pixel_b;
		end else begin
			res_d.out_r = gds_pkg::round_sum(col_sum.r);
			res_d.out_g = gds_pkg::round_sum(col_sum.g);
			res_d.out_b = gds_pkg::round_sum(col_sum.b);
		end
		res_d.frame_last = ctl_s1.last;
	end

	// block row complete: fold into the column entry
	assign wr_en   = adv && !ctl_s1.bypass && (ctl_s1.phase_x == gds_pkg::PH_LAST);
	assign wr_addr = ctl_s1.col;
	assign wr_data = col_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (adv && ctl_s1.emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			px_s1  <= in_data;
			ctl_s1 <= in_ctl;
		end
		if (adv && !ctl_s1.bypass) begin
			row_acc_q <= row_sum;
		end
		if (adv && ctl_s1.emit) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

// ===== rtl/gaussian_3x_downsample.sv =====
// gaussian_3x_downsample: top level of the 1-2-1 weighted 3x block downsampler
//
// Takes one three-channel pixel per clock in raster order and, in filter mode,
// emits one result per non-overlapping 3x3 block of the input, weighted
// 1-2-1 / 2-4-2 / 1-2-1 and divided by 16 with rounding half up; the input
// frame is then 3*out_width by 3*out_height pixels. In bypass mode every pixel
// comes out unchanged and the frame is out_width by out_height. frame_last
// marks the final result of each frame. A pixel beat can be taken on every
// clock while the input stage is not held: the sustained rate is one pixel
// per cycle, set by the read-modify-write of the column partial-sum store
// (1024 x 60 bits, one write and one registered read port). A beat is held in
// the input stage, where the store read lands, and its result is loaded into
// the result register at the edge that retires it, from where it can be taken
// when the output is ready. In filter mode beats that complete no block leave
// the input stage whatever the output does, so input keeps flowing while a
// result waits; a beat that completes a block, and every bypass beat, holds in
// the input stage until the result register is free,
// and input stalls behind it.
// Configuration writes restart the frame counters; write them only while the
// block is idle. Zero dimensions act as one, dimensions above 1024 as 1024.
// The partial-sum store is not cleared; every entry is written in the first
// row of a block row before its contents are used.
module gaussian_3x_downsample (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [gds_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [gds_pkg::DIM_W-1:0]       cfg_wdata,
	gds_pix_if.snk                          pixel,
	gds_res_if.src                          result
);

	gds_pkg::ctl_t   nxt_ctl;
	gds_pkg::sum3_t  col_rd;
	gds_pkg::sum3_t  col_wr_data;
	gds_pkg::col_t   col_wr_addr;
	logic            col_wr_en;
	logic            pix_ready;
	logic            accept;

	// input beat taken
	assign accept      = pixel.valid && pix_ready;
	assign pixel.ready = pix_ready;

	// raster and block position counters plus configuration registers
	gds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.nxt       (nxt_ctl)
	);

	// column entry is fetched as the beat enters, so it lines up with the input stage
	gds_line_store u_line_store (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (nxt_ctl.col),
		.rd_data (col_rd),
		.wr_en   (col_wr_en),
		.wr_addr (col_wr_addr),
		.wr_data (col_wr_data)
	);

	// weighting, accumulation, rounding and output register
	gds_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_data   (pixel.data),
		.in_ctl    (nxt_ctl),
		.in_ready  (pix_ready),
		.col_rd    (col_rd),
		.wr_en     (col_wr_en),
		.wr_addr   (col_wr_addr),
		.wr_data   (col_wr_data),
		.res_valid (result.valid),
		.res_ready (result.ready),
		.res_data  (result.data)
	);

	// block column phase always wraps after its third pixel
	a_phase_wrap : assert property (@(posedge clk) disable iff (!arst_n)
		accept && (nxt_ctl.phase_x == gds_pkg::PH_LAST) |=> nxt_ctl.phase_x == gds_pkg::PH_FIRST)
		else $error("block column phase did not wrap");

	// bypass mode keeps both block phases at zero
	a_bypass_phase : assert property (@(posedge clk) disable iff (!arst_n)
		nxt_ctl.bypass |-> (nxt_ctl.phase_x == gds_pkg::PH_FIRST)
			&& (nxt_ctl.phase_y == gds_pkg::PH_FIRST))
		else $error("block phase moved in bypass mode");

	// frame end is only flagged on a beat that produces a result
	a_last_emits : assert property (@(posedge clk) disable iff (!arst_n)
		nxt_ctl.last |-> nxt_ctl.emit)
		else $error("frame end flagged on a beat with no result");

	// the store is only written on the final pixel of a block row and not in bypass mode
	a_store_write : assert property (@(posedge clk) disable iff (!arst_n)
		col_wr_en |-> !nxt_ctl.bypass || $past(!nxt_ctl.bypass))
		else $error("column store written in bypass mode");

endmodule

// ===== dv/gds_downsample_checker.sv =====
// gds_downsample_checker: watches both channels, predicts the results and compares them
`timescale 1ns / 100ps

module gds_downsample_checker
	import gds_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  dim_t                 cfg_wdata,
	gds_pix_if                   pixel,
	gds_res_if                   result,
	output int                   errors,
	output int                   pending
);

	// register shadows
	logic filt_on;
	dim_t width_reg;
	dim_t height_reg;

	// partial sums: one block row per output column, one block row in progress
	sum_t   col_sum [MAX_OUT_W][3];
	sum_t   row_sum [3];
	int     in_col;
	int     row_idx;
	phase_t phase_x;
	phase_t phase_y;

	res_t due_pixels [$];

	// zero acts as one, anything past the store depth saturates
	function automatic int span(dim_t v);
		if (v == '0) begin
			return 1;
		end
		if (v > DIM_W'(MAX_OUT_W)) begin
			return MAX_OUT_W;
		end
		return int'(v);
	endfunction

	// steps to the next output row; true when the frame wraps
	function automatic bit close_row(int h);
		if (row_idx >= h - 1) begin
			row_idx = 0;
			return 1'b1;
		end
		row_idx++;
		return 1'b0;
	endfunction

	task automatic restart_frame();
		for (int c = 0; c < 3; c++) begin
			row_sum[c] = '0;
		end
		in_col  = 0;
		row_idx = 0;
		phase_x = PH_FIRST;
		phase_y = PH_FIRST;
	endtask

	task automatic flag_mismatch(string what, int got, int want);
		$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
		errors++;
	endtask

	task automatic r_check(res_t want);
		if (result.data.out_r !== want.out_r) begin
			flag_mismatch("out_r", result.data.out_r, want.out_r);
		end
		if (result.data.out_g !== want.out_g) begin
			flag_mismatch("out_g", result.data.out_g, want.out_g);
		end
		if (result.data.out_b !== want.out_b) begin
			flag_mismatch("out_b", result.data.out_b, want.out_b);
		end
		if (result.data.frame_last !== want.frame_last) begin
			flag_mismatch("frame_last", result.data.frame_last, want.frame_last);
		end
	endtask

	// one accepted pixel beat: update the sums and queue any result it completes
	task automatic fold_pixel(pix_t p);
		chan_t ch [3];
		chan_t avg [3];
		int    w;
		int    h;
		int    col;
		bit    emit;
		bit    last;
		res_t  r;
		ch[0] = p.pixel_r;
		ch[1] = p.pixel_g;
		ch[2] = p.pixel_b;
		w = span(width_reg);
		h = span(height_reg);
		emit = 1'b0;
		last = 1'b0;
		if (!filt_on) begin
			phase_x = PH_FIRST;
			phase_y = PH_FIRST;
			if (in_col >= w - 1) begin
				in_col = 0;
				last = close_row(h);
			end else begin
				in_col++;
			end
			r.out_r = ch[0];
			r.out_g = ch[1];
			r.out_b = ch[2];
			r.frame_last = last;
			due_pixels.push_back(r);
			return;
		end
		col = in_col / 3;
		if (col >= MAX_OUT_W) begin
			col = MAX_OUT_W - 1;
		end
		for (int c = 0; c < 3; c++) begin
			row_sum[c] = sum_t'(((phase_x == PH_FIRST) ? sum_t'(0) : row_sum[c])
				+ sum_t'(ch[c]) * ((phase_x == PH_MID) ? 2 : 1));
		end
		if (phase_x != PH_LAST) begin
			phase_x++;
			in_col++;
			return;
		end
		// block row done: fold into this column's running sum
		for (int c = 0; c < 3; c++) begin
			col_sum[col][c] = sum_t'(((phase_y == PH_FIRST) ? sum_t'(0) : col_sum[col][c])
				+ row_sum[c] * ((phase_y == PH_MID) ? 2 : 1));
		end
		if (phase_y == PH_LAST) begin
			emit = 1'b1;
			for (int c = 0; c < 3; c++) begin
				avg[c] = chan_t'((32'(col_sum[col][c]) + 8) >> 4);
			end
		end
		phase_x = PH_FIRST;
		if (col >= w - 1) begin
			in_col = 0;
			if (phase_y == PH_LAST) begin
				phase_y = PH_FIRST;
				last = close_row(h);
			end else begin
				phase_y++;
			end
		end else begin
			in_col++;
		end
		if (emit) begin
			r.out_r = avg[0];
			r.out_g = avg[1];
			r.out_b = avg[2];
			r.frame_last = last;
			due_pixels.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_on    = 1'b1;
			width_reg  = RST_WIDTH;
			height_reg = RST_HEIGHT;
			restart_frame();
			due_pixels.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_FILTER_ENABLE: begin
						filt_on = cfg_wdata[0];
						restart_frame();
					end
					REG_OUT_WIDTH: begin
						width_reg = cfg_wdata;
						restart_frame();
					end
					REG_OUT_HEIGHT: begin
						height_reg = cfg_wdata;
						restart_frame();
					end
					default: begin
					end
				endcase
			end
			if (result.valid && result.ready) begin
				if (due_pixels.size() == 0) begin
					flag_mismatch("result beat with nothing expected", result.data.out_r, 0);
				end else begin
					r_check(due_pixels.pop_front());
				end
			end
			if (pixel.valid && pixel.ready) begin
				fold_pixel(pixel.data);
			end
		end
		pending = due_pixels.size();
	end

endmodule

// ===== dv/tb_gaussian_3x_downsample.sv =====
// tb_gaussian_3x_downsample: stimulus, clock, reset and verdict for the 3x downsample block
`timescale 1ns / 100ps

module tb_gaussian_3x_downsample;
	import gds_pkg::*;

	// index with no register behind it; a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam int CYCLE_LIMIT  = 200000;
	// margin after the last expected result so the block can go quiet
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_ITEMS = 340;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	dim_t                 cfg_wdata;

	gds_pix_if pixel ();
	gds_res_if result ();

	// idle and stall rates in percent, changed per phase
	int idle_pct;
	int stall_pct;
	// request for one long receiver hold-off
	bit long_hold;
	// set by the sink once the hold-off has been served
	bit hold_done;

	int fail_count;
	int in_flight;
	int cycles;
	int sent;

	// shadow of the settings last written by the random part
	bit force_cfg;
	bit cur_filt;
	int cur_w;
	int cur_h;

	gaussian_3x_downsample i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.pixel     (pixel),
		.result    (result)
	);

	gds_downsample_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.pixel     (pixel),
		.result    (result),
		.errors    (fail_count),
		.pending   (in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop in case the block hangs or a result never shows up
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** gaussian_3x_downsample: FAILED **");
			$finish;
		end
	end

	// result sink: random stalls, plus one long hold-off on request
	initial begin
		result.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold && !hold_done) begin
				hold_done = 1'b1;
				result.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			result.ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
		end
	end

	// mostly full-range random, with the rails showing up often
	function automatic chan_t rand_chan();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return chan_t'($urandom);
		endcase
	endfunction

	function automatic pix_t rand_pix();
		pix_t p;
		p.pixel_r = rand_chan();
		p.pixel_g = rand_chan();
		p.pixel_b = rand_chan();
		return p;
	endfunction

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic send_pix(pix_t p);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			pixel.valid <= 1'b0;
			@(negedge clk);
		end
		pixel.valid <= 1'b1;
		pixel.data  <= p;
		@(posedge clk);
		while (!pixel.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// write enable drops for a cycle between writes
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, dim_t val);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// wait until every expected result is out and the block has gone quiet
	task automatic settle();
		pixel.valid <= 1'b0;
		while (in_flight != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// one stretch of random traffic, usually under fresh settings
	task automatic run_segment();
		dim_t wv;
		dim_t hv;
		int   n;
		settle();
		if (force_cfg || $urandom_range(3) != 0) begin
			force_cfg = 1'b0;
			cur_filt = $urandom_range(2) != 0;
			cur_w = cur_filt ? $urandom_range(1, 5) : $urandom_range(1, 12);
			cur_h = cur_filt ? $urandom_range(1, 3) : $urandom_range(1, 6);
			// zero dimensions read as one
			wv = (cur_w == 1 && $urandom_range(1)) ? dim_t'(0) : dim_t'(cur_w);
			hv = (cur_h == 1 && $urandom_range(1)) ? dim_t'(0) : dim_t'(cur_h);
			write_reg(REG_FILTER_ENABLE, dim_t'(cur_filt));
			write_reg(REG_OUT_WIDTH, wv);
			write_reg(REG_OUT_HEIGHT, hv);
		end
		if (cur_filt) begin
			n = 9 * cur_w * cur_h;
		end else begin
			n = $urandom_range(1, 3) * cur_w * cur_h;
		end
		// sometimes stop mid-frame so the next write restarts it
		if ($urandom_range(4) == 0) begin
			n = $urandom_range(1, n);
		end
		repeat (n) send_pix(rand_pix());
		sent += n;
	endtask

	initial begin
		pix_t p;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_idx     = REG_FILTER_ENABLE;
		cfg_wdata   = '0;
		pixel.valid = 1'b0;
		pixel.data  = '0;
		idle_pct    = 0;
		stall_pct   = 0;
		long_hold   = 1'b0;
		sent        = 0;
		force_cfg   = 1'b1;
		cur_filt    = 1'b1;
		cur_w       = 1;
		cur_h       = 1;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: 1x1 output, filter on
		write_reg(REG_FILTER_ENABLE, 11'd1);
		write_reg(REG_OUT_WIDTH, 11'd1);
		write_reg(REG_OUT_HEIGHT, 11'd1);
		// full-scale block: largest sum, must land exactly on full scale
		p = '1;
		repeat (9) send_pix(p);
		// only the center tap set: exercises round half up and round down
		for (int i = 0; i < 9; i++) begin
			p = '0;
			if (i == 4) begin
				p.pixel_r = 16'd2;
				p.pixel_g = 16'd1;
				p.pixel_b = 16'd3;
			end
			send_pix(p);
		end
		settle();
		// bypass with zero dimensions: every pixel is a whole frame
		write_reg(REG_FILTER_ENABLE, 11'd0);
		write_reg(REG_OUT_WIDTH, 11'd0);
		write_reg(REG_OUT_HEIGHT, 11'd0);
		send_pix('0);
		send_pix('1);
		settle();
		// write to an unmapped index: frame state carries on
		write_reg(REG_SPARE, '1);
		send_pix(rand_pix());
		settle();

		// oversized dimensions saturate at the store depth; only the start of each frame
		write_reg(REG_FILTER_ENABLE, 11'd1);
		write_reg(REG_OUT_WIDTH, '1);
		write_reg(REG_OUT_HEIGHT, 11'd0);
		repeat (18) send_pix(rand_pix());
		settle();
		write_reg(REG_FILTER_ENABLE, 11'd0);
		write_reg(REG_OUT_WIDTH, 11'd1);
		write_reg(REG_OUT_HEIGHT, dim_t'(MAX_OUT_W + 1));
		repeat (24) send_pix(rand_pix());
		settle();
		write_reg(REG_OUT_WIDTH, dim_t'(MAX_OUT_W));
		write_reg(REG_OUT_HEIGHT, 11'd1);
		repeat (24) send_pix(rand_pix());
		settle();
		// tall filter frame, only its first block rows
		write_reg(REG_FILTER_ENABLE, 11'd1);
		write_reg(REG_OUT_WIDTH, 11'd1);
		write_reg(REG_OUT_HEIGHT, dim_t'(MAX_OUT_W));
		repeat (27) send_pix(rand_pix());
		force_cfg = 1'b1;

		// random part in four idling phases
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 82; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 82; end
				default: begin idle_pct = 33; stall_pct = 33; end
			endcase
			if (ph == 0) begin
				// sink holds off while bypass pixels keep coming: the block fills and backs up
				settle();
				cur_filt = 1'b0;
				cur_w = 4;
				cur_h = 5;
				write_reg(REG_FILTER_ENABLE, 11'd0);
				write_reg(REG_OUT_WIDTH, dim_t'(cur_w));
				write_reg(REG_OUT_HEIGHT, dim_t'(cur_h));
				long_hold = 1'b1;
				repeat (40) send_pix(rand_pix());
				sent += 40;
			end
			while (sent < (ph + 1) * RANDOM_ITEMS / 4) run_segment();
		end

		settle();
		if (fail_count == 0) begin
			$display("** gaussian_3x_downsample: PASSED **");
		end else begin
			$display("** gaussian_3x_downsample: FAILED **");
		end
		$finish;
	end

endmodule
